// ----- hdl/csd_pkg.sv -----
// ----------------------------------------------------------------------------
// csd_pkg
// Types and constants shared by the charset byte decoder: charset and byte
// order codes, decoder state, and the result unit records.
// ----------------------------------------------------------------------------
`default_nettype none

package csd_pkg;

   // charset selector codes, values six and seven act as utf-16 with mark
   typedef enum logic [2:0] {
      CS_UTF8     = 3'd0,
      CS_LATIN1   = 3'd1,
      CS_ASCII    = 3'd2,
      CS_UTF16BE  = 3'd3,
      CS_UTF16LE  = 3'd4,
      CS_UTF16BOM = 3'd5
   } charset_kind_type;

   // byte order learned from the mark in utf-16 with mark mode
   typedef enum logic [1:0] {
      ORDER_UNKNOWN = 2'd0,
      ORDER_BIG     = 2'd1,
      ORDER_LITTLE  = 2'd2
   } byte_order_type;

   localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
   localparam logic [15:0] NONCHAR     = 16'hFFFE;
   localparam logic [15:0] HIGH_SURR   = 16'hD800;
   localparam logic [15:0] LOW_SURR    = 16'hDC00;
   localparam logic [15:0] SURR_MASK   = 16'hFC00;
   localparam logic [20:0] SUPP_BASE   = 21'h10000;
   localparam logic [7:0]  LEAD_MIN    = 8'hC2;
   localparam logic [7:0]  LEAD_MAX    = 8'hF4;
   localparam logic [7:0]  CONT_MASK   = 8'hC0;
   localparam logic [7:0]  CONT_TAG    = 8'h80;
   localparam logic [7:0]  BOM_HI      = 8'hFE;
   localparam logic [7:0]  BOM_LO      = 8'hFF;

   // decoder state besides the held bytes
   typedef struct packed {
      logic [1:0]     held_count;
      byte_order_type byte_order;
   } state_type;

   // decoder step control: next state and held byte write strobes
   typedef struct packed {
      state_type  nx_state;
      logic [2:0] held_wr;
   } decode_ctl_type;

   // one result unit
   typedef struct packed {
      logic [15:0] code_unit;
      logic        replaced;
      logic        last_of_run;
   } unit_type;

   // all results of one request, slot0 first
   typedef struct packed {
      logic [1:0] count;
      unit_type   slot0;
      unit_type   slot1;
   } pair_type;

endpackage

`default_nettype wire

// ----- hdl/csd_req_if.sv -----
// ----------------------------------------------------------------------------
// csd_req_if
// Request channel: one encoded byte and its end of input mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface csd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_input;

   modport source (output valid, output data_byte, output end_of_input, input ready);
   modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

// ----- hdl/csd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// csd_rsp_if
// Response channel: one decoded utf-16 code unit with its flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface csd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        replaced;
   logic        last_of_run;

   modport source (output valid, output code_unit, output replaced, output last_of_run,
                   input ready);
   modport sink   (input valid, input code_unit, input replaced, input last_of_run,
                   output ready);
endinterface

`default_nettype wire

// ----- hdl/csd_decode.sv -----
// ----------------------------------------------------------------------------
// csd_decode
// Combinational step of the decoder: from the current state, the held bytes
// and one byte, gives the next state, held byte writes and up to two units.
// ----------------------------------------------------------------------------
`default_nettype none

module csd_decode
   import csd_pkg::*;
(
   input  wire logic [2:0]  charset_kind,
   input  wire state_type   cur_state,
   input  wire logic [7:0]  held0,
   input  wire logic [7:0]  held1,
   input  wire logic [7:0]  held2,
   input  wire logic [7:0]  data_byte,
   input  wire logic        end_of_input,
   output decode_ctl_type   ctl,
   output pair_type         pair
);

   typedef enum logic [1:0] {
      LEAD_ASCII,
      LEAD_HOLD,
      LEAD_BAD
   } lead_class_type;

   // class of a byte that starts a utf-8 sequence
   function automatic lead_class_type lead_class(input logic [7:0] b);
      lead_class_type r;
      if (b < CONT_TAG) r = LEAD_ASCII;
      else if (b >= LEAD_MIN && b <= LEAD_MAX) r = LEAD_HOLD;
      else r = LEAD_BAD;
      return r;
   endfunction

   // continuation byte check, with the narrowed second byte ranges
   function automatic logic cont_ok(input logic [7:0] lead, input logic second,
                                    input logic [7:0] b);
      logic r;
      r = ((b & CONT_MASK) == CONT_TAG);
      if (second && lead == 8'hE0) r = (b >= 8'hA0 && b <= 8'hBF);
      if (second && lead == 8'hF0) r = (b >= 8'h90 && b <= 8'hBF);
      if (second && lead == 8'hF4) r = (b >= 8'h80 && b <= 8'h8F);
      return r;
   endfunction

   function automatic logic [15:0] join16(input logic [7:0] first, input logic [7:0] second,
                                          input logic big);
      return big ? {first, second} : {second, first};
   endfunction

   function automatic logic is_low(input logic [15:0] c);
      return (c & SURR_MASK) == LOW_SURR;
   endfunction

   function automatic logic is_high(input logic [15:0] c);
      return (c & SURR_MASK) == HIGH_SURR;
   endfunction

   logic [1:0]     cnt;
   logic [1:0]     nx_count;
   byte_order_type nx_order;
   logic [2:0]     held_wr;
   logic           a_v, a_r, b_v, b_r, z_v;
   logic [15:0]    a_u, b_u;
   logic           run_u16;
   logic           big;
   logic [2:0]     need;
   logic [15:0]    c3;
   logic [20:0]    uc;
   logic [20:0]    uc_off;
   logic [15:0]    c_one, c_pair, c_two;
   lead_class_type lc_cur;

   assign cnt = cur_state.held_count;

   // utf-8 payload assembly
   always_comb begin
      c3     = {held0[3:0], held1[5:0], data_byte[5:0]};
      uc     = {held0[2:0], held1[5:0], held2[5:0], data_byte[5:0]};
      uc_off = uc - SUPP_BASE;
      lc_cur = lead_class(data_byte);
   end

   // utf-16 byte order: fixed for the set orders, else big endian until a mark says otherwise
   always_comb begin
      unique case (charset_kind)
         CS_UTF16LE: big = 1'b0;
         CS_UTF8, CS_LATIN1, CS_ASCII, CS_UTF16BE: big = 1'b1;
         default: big = (cur_state.byte_order != ORDER_LITTLE);
      endcase
   end

   // utf-16 unit assembly
   always_comb begin
      c_one  = join16(held0, data_byte, big);
      c_pair = join16(held0, held1, big);
      c_two  = join16(held2, data_byte, big);
   end

   // per-charset step
   always_comb begin
      nx_count = cnt;
      nx_order = cur_state.byte_order;
      held_wr  = '0;
      a_v = 1'b0; a_u = '0; a_r = 1'b0;
      b_v = 1'b0; b_u = '0; b_r = 1'b0;
      run_u16 = 1'b0;
      need    = (held0 < 8'hE0) ? 3'd2 : ((held0 < 8'hF0) ? 3'd3 : 3'd4);

      unique case (charset_kind)
         CS_UTF8: begin
            if (cnt == 2'd0) begin
               unique case (lc_cur)
                  LEAD_ASCII: begin
                     a_v = 1'b1; a_u = {8'h00, data_byte};
                  end
                  LEAD_HOLD: begin
                     held_wr[0] = 1'b1; nx_count = 2'd1;
                  end
                  default: begin
                     a_v = 1'b1; a_u = REPL_UNIT; a_r = 1'b1;
                  end
               endcase
            end else if (!cont_ok(held0, cnt == 2'd1, data_byte)) begin
               // broken sequence: replace, then this byte starts afresh
               a_v = 1'b1; a_u = REPL_UNIT; a_r = 1'b1;
               nx_count = 2'd0;
               unique case (lc_cur)
                  LEAD_ASCII: begin
                     b_v = 1'b1; b_u = {8'h00, data_byte};
                  end
                  LEAD_HOLD: begin
                     held_wr[0] = 1'b1; nx_count = 2'd1;
                  end
                  default: begin
                     b_v = 1'b1; b_u = REPL_UNIT; b_r = 1'b1;
                  end
               endcase
            end else if ({1'b0, cnt} + 3'd1 < need) begin
               held_wr[cnt] = 1'b1;
               nx_count = cnt + 2'd1;
            end else begin
               nx_count = 2'd0;
               priority case (need)
                  3'd2: begin
                     a_v = 1'b1; a_u = {5'b0, held0[4:0], data_byte[5:0]};
                  end
                  3'd3: begin
                     a_v = 1'b1;
                     if (is_low(c3) || is_high(c3)) begin
                        a_u = REPL_UNIT; a_r = 1'b1;
                     end else begin
                        a_u = c3;
                     end
                  end
                  default: begin
                     a_v = 1'b1; a_u = HIGH_SURR | {6'b0, uc_off[19:10]};
                     b_v = 1'b1; b_u = LOW_SURR | {6'b0, uc_off[9:0]};
                  end
               endcase
            end
         end
         CS_LATIN1: begin
            nx_count = 2'd0;
            a_v = 1'b1; a_u = {8'h00, data_byte};
         end
         CS_ASCII: begin
            nx_count = 2'd0;
            a_v = 1'b1;
            if (data_byte < CONT_TAG) a_u = {8'h00, data_byte};
            else begin
               a_u = REPL_UNIT; a_r = 1'b1;
            end
         end
         CS_UTF16BE: begin
            run_u16 = 1'b1;
         end
         CS_UTF16LE: begin
            run_u16 = 1'b1;
         end
         default: begin
            // byte order mark detection, then utf-16 in the learned order
            if (cur_state.byte_order == ORDER_UNKNOWN) begin
               if (cnt == 2'd0) begin
                  held_wr[0] = 1'b1; nx_count = 2'd1;
               end else if (held0 == BOM_HI && data_byte == BOM_LO) begin
                  nx_order = ORDER_BIG; nx_count = 2'd0;
               end else if (held0 == BOM_LO && data_byte == BOM_HI) begin
                  nx_order = ORDER_LITTLE; nx_count = 2'd0;
               end else begin
                  nx_order = ORDER_BIG;
                  run_u16 = 1'b1;
               end
            end else begin
               run_u16 = 1'b1;
            end
         end
      endcase

      // utf-16 unit and surrogate pair handling
      if (run_u16) begin
         unique case (cnt)
            2'd0, 2'd2: begin
               held_wr[cnt] = 1'b1;
               nx_count = cnt + 2'd1;
            end
            2'd1: begin
               if (c_one == NONCHAR || is_low(c_one)) begin
                  a_v = 1'b1; a_u = REPL_UNIT; a_r = 1'b1;
                  nx_count = 2'd0;
               end else if (is_high(c_one)) begin
                  held_wr[1] = 1'b1; nx_count = 2'd2;
               end else begin
                  a_v = 1'b1; a_u = c_one;
                  nx_count = 2'd0;
               end
            end
            default: begin
               nx_count = 2'd0;
               a_v = 1'b1;
               if (is_low(c_two)) begin
                  a_u = c_pair;
                  b_v = 1'b1; b_u = c_two;
               end else begin
                  a_u = REPL_UNIT; a_r = 1'b1;
               end
            end
         endcase
      end

      // end of input: incomplete tail is replaced, state returns to reset
      z_v = 1'b0;
      if (end_of_input) begin
         z_v = (nx_count != 2'd0);
         nx_count = 2'd0;
         nx_order = ORDER_UNKNOWN;
      end
   end

   // pack the results in order, flag the last one
   always_comb begin
      pair.count = {1'b0, a_v} + {1'b0, b_v} + {1'b0, z_v};
      pair.slot0 = '0;
      pair.slot1 = '0;
      priority if (a_v) begin
         pair.slot0 = '{code_unit: a_u, replaced: a_r, last_of_run: 1'b0};
         if (b_v) pair.slot1 = '{code_unit: b_u, replaced: b_r, last_of_run: 1'b0};
         else     pair.slot1 = '{code_unit: REPL_UNIT, replaced: 1'b1, last_of_run: 1'b0};
      end else if (b_v) begin
         pair.slot0 = '{code_unit: b_u, replaced: b_r, last_of_run: 1'b0};
         pair.slot1 = '{code_unit: REPL_UNIT, replaced: 1'b1, last_of_run: 1'b0};
      end else begin
         pair.slot0 = '{code_unit: REPL_UNIT, replaced: 1'b1, last_of_run: 1'b0};
      end
      if (pair.count == 2'd1) pair.slot0.last_of_run = 1'b1;
      pair.slot1.last_of_run = 1'b1;
   end

   assign ctl.nx_state.held_count = nx_count;
   assign ctl.nx_state.byte_order = nx_order;
   assign ctl.held_wr             = held_wr;

endmodule

`default_nettype wire

// ----- hdl/csd_out_buf.sv -----
// ----------------------------------------------------------------------------
// csd_out_buf
// Three-unit result queue. Takes all units of one request at once whenever
// two places are free, and shows the oldest unit on the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module csd_out_buf
   import csd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     load,
   input  wire pair_type pair,
   output logic          can_load,
   csd_rsp_if.source     rsp_chan
);

   logic [1:0] cnt_ff, cnt_in;
   unit_type   q_ff [3];
   unit_type   q_in [3];
   logic       pop;
   logic [1:0] rem;

   assign pop      = rsp_chan.valid & rsp_chan.ready;
   assign can_load = (cnt_ff <= 2'd1);

   // response channel shows the head
   assign rsp_chan.valid       = (cnt_ff != 2'd0);
   assign rsp_chan.code_unit   = q_ff[0].code_unit;
   assign rsp_chan.replaced    = q_ff[0].replaced;
   assign rsp_chan.last_of_run = q_ff[0].last_of_run;

   // shift out on pop, then append the new units behind what remains
   always_comb begin
      q_in[0] = pop ? q_ff[1] : q_ff[0];
      q_in[1] = pop ? q_ff[2] : q_ff[1];
      q_in[2] = q_ff[2];
      rem     = cnt_ff - {1'b0, pop};
      cnt_in  = rem;
      if (load) begin
         for (int i = 0; i < 3; i++) begin
            if (2'(i) == rem) q_in[i] = pair.slot0;
            if (2'(i) == rem + 2'd1) q_in[i] = pair.slot1;
         end
         cnt_in = rem + pair.count;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) q_ff[i] <= q_in[i];
   end

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/charset_byte_decoder.sv -----
// ----------------------------------------------------------------------------
// charset_byte_decoder
// Byte-serial decoder from UTF-8, Latin-1, ASCII or UTF-16 (fixed order or
// order from a mark) to UTF-16 code units, with replacement of bad input.
// ----------------------------------------------------------------------------
//
//   channel    dir  handshake          payload
//   req_chan   in   valid / ready      data_byte[7:0], end_of_input
//   rsp_chan   out  valid / ready      code_unit[15:0], replaced, last_of_run
//   csr        in   csr_wr_en          csr_wr_data[2:0] (charset_kind)
//
// One request per cycle while the queue can take a load: a request waits in the
// input register, is decoded against the held state, and its zero to two units
// enter a three-unit queue when two places are free. Requests giving two units
// each are slowed by the single response port.
// Reset clears the charset (UTF-8), the held count and the byte order.
// Ready depends only on registers; a stalled response side fills the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module charset_byte_decoder
   import csd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   csd_req_if.sink         req_chan,
   csd_rsp_if.source       rsp_chan,
   input  wire logic       csr_wr_en,
   input  wire logic [2:0] csr_wr_data
);

   logic           in_valid_ff;
   logic [7:0]     in_byte_ff;
   logic           in_end_ff;
   logic [2:0]     kind_ff;
   state_type      state_ff;
   logic [7:0]     held_ff [3];
   logic           can_load;
   logic           advance;
   decode_ctl_type ctl;
   pair_type       pair;

   assign advance        = in_valid_ff & can_load;
   assign req_chan.ready = ~in_valid_ff | can_load;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid & req_chan.ready) begin
         in_byte_ff <= req_chan.data_byte;
         in_end_ff  <= req_chan.end_of_input;
      end
   end

   // charset register and decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= CS_UTF8;
         state_ff <= '{held_count: 2'd0, byte_order: ORDER_UNKNOWN};
      end else if (csr_wr_en) begin
         kind_ff  <= csr_wr_data;
         state_ff <= '{held_count: 2'd0, byte_order: ORDER_UNKNOWN};
      end else if (advance) begin
         state_ff <= ctl.nx_state;
      end
   end

   // held bytes of an unfinished sequence
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (advance && ctl.held_wr[i]) held_ff[i] <= in_byte_ff;
      end
   end

   csd_decode u_decode (
      .charset_kind (kind_ff),
      .cur_state    (state_ff),
      .held0        (held_ff[0]),
      .held1        (held_ff[1]),
      .held2        (held_ff[2]),
      .data_byte    (in_byte_ff),
      .end_of_input (in_end_ff),
      .ctl          (ctl),
      .pair         (pair)
   );

   csd_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .pair     (pair),
      .can_load (can_load),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
